@@ hdl/pseudo3d_road_segment_projector_top_defines.svh @@
// assertion macros for the road segment projector
// used by the top level; expects clk and rst_n in the including scope
`ifndef PSEUDO3D_ROAD_SEGMENT_PROJECTOR_TOP_DEFINES_SVH
`define PSEUDO3D_ROAD_SEGMENT_PROJECTOR_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication check
`define P3DRSP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("p3drsp: same-cycle check failed");
// next-cycle implication check
`define P3DRSP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("p3drsp: next-cycle check failed");
`else
`define P3DRSP_ASSERT_IMP(lbl, ante, cons)
`define P3DRSP_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

@@ hdl/p3drsp_pkg.sv @@
// shared types, widths, constants and helper functions of the road projector
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package p3drsp_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAMERA_DEPTH  = 2'd0,
    CFG_ROAD_WIDTH    = 2'd1,
    CFG_SCREEN_WIDTH  = 2'd2,
    CFG_SCREEN_HEIGHT = 2'd3
  } cfg_idx_t;

  // register widths and reset values
  localparam int DEPTH_W = 15;
  localparam int ROADW_W = 16;
  localparam int SCR_W   = 12;

  localparam logic [DEPTH_W-1:0] DEPTH_RST  = 15'd14746;
  localparam logic [ROADW_W-1:0] ROADW_RST  = 16'd2000;
  localparam logic [SCR_W-1:0]   SCR_W_RST  = 12'd1024;
  localparam logic [SCR_W-1:0]   SCR_H_RST  = 12'd768;

  // shared multiplier operand widths
  localparam int MUL_A_W = 29;
  localparam int MUL_B_W = 16;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // shared divider widths
  localparam int DIV_DEN_W = 24;
  localparam int DIV_Q_W   = 16;
  localparam int DIV_NUM_W = DIV_DEN_W + DIV_Q_W;

  // projection datapath widths
  localparam int T_W     = 42;  // term before the screen scale
  localparam int N_W     = 54;  // full numerator
  localparam int SPLIT_W = 21;  // low half of the term for the two-pass multiply
  localparam int N_SHR   = 15;  // 32768 factor of the denominator

  // reciprocal constants for the small fixed divisions
  localparam logic [15:0] RECIP3 = 16'd43691;  // ceil(2^17 / 3)
  localparam int          RECIP3_SHR = 17;
  localparam logic [15:0] RECIP5 = 16'd52429;  // ceil(2^18 / 5)
  localparam int          RECIP5_SHR = 18;

  // one input item
  typedef struct packed {
    logic               first_of_frame;
    logic signed [23:0] cam_x;
    logic [15:0]        cam_height;
    logic [23:0]        cam_z;
    logic signed [23:0] seg_x;
    logic signed [15:0] seg_y;
    logic [23:0]        seg_z;
    logic signed [15:0] seg_curve;
    logic [15:0]        seg_index;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic               visible;
    logic               stripe;
    logic signed [15:0] near_x;
    logic signed [15:0] near_y;
    logic [15:0]        near_half_w;
    logic [15:0]        near_rumble_w;
    logic signed [15:0] far_x;
    logic signed [15:0] far_y;
    logic [15:0]        far_half_w;
    logic [15:0]        far_rumble_w;
  } out_item_t;

  // divider status toward the sequencer
  typedef struct packed {
    logic done;
    logic ovf;
  } div_stat_t;

  // band parity: (n / 3) % 2 by reciprocal multiply
  function automatic logic stripe_of(input logic [15:0] idx);
    logic [31:0] p;
    p = 32'(idx) * 32'(RECIP3);
    return p[RECIP3_SHR];
  endfunction

  // rumble width: min(65535, h + h / 5)
  function automatic logic [15:0] rumble_of(input logic [15:0] h);
    logic [33:0] p;
    logic [16:0] s;
    p = 34'(h) * 34'(RECIP5);
    s = {1'b0, h} + {1'b0, p[RECIP5_SHR+15:RECIP5_SHR]};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

endpackage

`default_nettype wire

@@ hdl/p3drsp_mul.sv @@
// shared signed multiplier with a registered product
// parameter defaults come from p3drsp_pkg
`timescale 1ns / 1ps
`default_nettype none

module p3drsp_mul #(
  parameter int A_W = p3drsp_pkg::MUL_A_W,
  parameter int B_W = p3drsp_pkg::MUL_B_W
) (
  input  logic                     clk,
  input  logic signed [A_W-1:0]    a,
  input  logic signed [B_W-1:0]    b,
  output logic signed [A_W+B_W-1:0] p
);

  logic signed [A_W+B_W-1:0] p_r;

  // product is registered and lands in the cycle after the operands
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

  assign p = p_r;

endmodule

`default_nettype wire

@@ hdl/p3drsp_div.sv @@
// restoring divider, one quotient bit per cycle, with quotient overflow flag
// parameter defaults come from p3drsp_pkg
`timescale 1ns / 1ps
`default_nettype none

module p3drsp_div #(
  parameter int DEN_W = p3drsp_pkg::DIV_DEN_W,
  parameter int Q_W   = p3drsp_pkg::DIV_Q_W
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [DEN_W+Q_W-1:0]   num,
  input  logic [DEN_W-1:0]       den,
  output logic [Q_W-1:0]         quo,
  output p3drsp_pkg::div_stat_t  stat
);

  localparam int NUM_W = DEN_W + Q_W;
  localparam int CNT_W = $clog2(Q_W);

  logic             run_r;
  logic             done_r;
  logic             ovf_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [Q_W-1:0]   qs_r;
  logic [DEN_W-1:0] den_r;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // one subtract and compare per step
  assign trial = {rem_r, qs_r[Q_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  // step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(Q_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[NUM_W-1:Q_W];
      qs_r  <= num[Q_W-1:0];
      den_r <= den;
      ovf_r <= num >= {den, {Q_W{1'b0}}};
    end else if (run_r) begin
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      qs_r  <= {qs_r[Q_W-2:0], ge};
    end
  end

  assign quo       = qs_r;
  assign stat.done = done_r;
  assign stat.ovf  = ovf_r;

endmodule

`default_nettype wire

@@ hdl/pseudo3d_road_segment_projector_top.sv @@
// top level of the pseudo-3d road segment projector: sequencer, state, ports
// depends on p3drsp_pkg, p3drsp_mul, p3drsp_div and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none

`include "pseudo3d_road_segment_projector_top_defines.svh"

// Projects one road segment per transfer, nearest first, into near/far screen
// edges. A segment in front of the camera goes through two setup states
// (S_PREP, S_QX), then three passes (x, y, half width) over one shared 29x16
// multiplier, then S_FIN, which loads the result. Each pass ends in a 16-step
// restoring division by the depth. A segment at or behind the camera skips the
// passes and goes from S_QX straight to S_FIN. in_stall is high from acceptance
// until the result has been loaded into the output register, so a new segment
// is taken only after the result of the last one is loaded. A result waiting
// on out_stall does not stop the next segment from being accepted and worked
// on; only the load of that next result waits for it.
// Configuration is to be written through cfg_we/cfg_index/cfg_wdata only while
// idle; the user must keep to this, as the block itself does not enforce it.
module pseudo3d_road_segment_projector_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  p3drsp_pkg::in_item_t                in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output p3drsp_pkg::out_item_t               out_data,
  input  logic                                cfg_we,
  input  logic [p3drsp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [p3drsp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  import p3drsp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_QX, S_M1, S_T, S_M2L, S_M2H, S_N, S_DS, S_DIV, S_FIN
  } state_t;

  typedef enum logic [1:0] {
    PASS_X, PASS_Y, PASS_W
  } pass_t;

  // control and state
  state_t                 state_r, state_nxt;
  pass_t                  pass_r, pass_nxt;
  logic [DEPTH_W-1:0]     depth_r, depth_nxt;
  logic [ROADW_W-1:0]     roadw_r, roadw_nxt;
  logic [SCR_W-1:0]       scr_w_r, scr_w_nxt;
  logic [SCR_W-1:0]       scr_h_r, scr_h_nxt;
  logic [31:0]            off_r, off_nxt;
  logic [31:0]            slope_r, slope_nxt;
  logic [15:0]            horizon_r, horizon_nxt;
  logic [15:0]            last_x_r, last_x_nxt;
  logic [15:0]            last_y_r, last_y_nxt;
  logic [15:0]            last_w_r, last_w_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // working registers
  in_item_t               in_r, in_nxt;
  out_item_t              out_data_r, out_data_nxt;
  logic [DIV_DEN_W-1:0]   dz_r, dz_nxt;
  logic                   dzpos_r, dzpos_nxt;
  logic [24:0]            camlat_r, camlat_nxt;
  logic [25:0]            qx_r, qx_nxt;
  logic [17:0]            qy_r, qy_nxt;
  logic                   stripe_r, stripe_nxt;
  logic [T_W-1:0]         t_r, t_nxt;
  logic [N_W-1:0]         n_r, n_nxt;
  logic                   neg_r, neg_nxt;
  logic [15:0]            fx_r, fx_nxt;
  logic [15:0]            fy_r, fy_nxt;
  logic [15:0]            fw_r, fw_nxt;
  logic                   y_under_r, y_under_nxt;

  // shared units
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod;
  logic                      div_start;
  logic [DIV_NUM_W-1:0]      div_num;
  logic [DIV_Q_W-1:0]        div_q;
  div_stat_t                 div_stat;

  // combinational helpers
  logic [24:0]            dz_w;
  logic [32:0]            lat_w;
  logic [MUL_B_W-1:0]     scale_b;
  logic [T_W-1:0]         dz14;
  logic [N_W-N_SHR-1:0]   n_shr;
  logic                   sat_s;
  logic [15:0]            sval;
  logic [15:0]            wval;
  logic                   vis_c;
  logic                   fin_load;

  p3drsp_mul #(
    .A_W (MUL_A_W),
    .B_W (MUL_B_W)
  ) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  p3drsp_div #(
    .DEN_W (DIV_DEN_W),
    .Q_W   (DIV_Q_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (dz_r),
    .quo   (div_q),
    .stat  (div_stat)
  );

  // depth difference and curve-bent camera position
  assign dz_w  = {1'b0, in_r.seg_z} - {1'b0, in_r.cam_z};
  assign lat_w = {in_r.cam_x[23], in_r.cam_x, 8'h00} - {off_r[31], off_r};
  assign dz14  = {4'b0000, dz_r, 14'b0};

  // screen scale of the current pass
  always_comb begin
    unique case (pass_r)
      PASS_X:  scale_b = {4'b0000, scr_w_r};
      PASS_Y:  scale_b = {4'b0000, scr_h_r};
      PASS_W:  scale_b = {1'b0, depth_r};
      default: scale_b = '0;
    endcase
  end

  // divider numerator: floor by 32768, then magnitude for floor division
  assign n_shr   = n_r[N_W-1:N_SHR];
  assign div_num = {1'b0, (n_r[N_W-1] ? ~n_shr : n_shr)};

  // saturated quotient
  assign sat_s = div_stat.ovf || div_q[15];
  assign sval  = sat_s ? (neg_r ? 16'h8000 : 16'h7FFF) : (neg_r ? ~div_q : div_q);
  assign wval  = div_stat.ovf ? 16'hFFFF : div_q;

  // horizon test on the unsaturated y
  assign vis_c    = dzpos_r && (y_under_r || ($signed(fy_r) < $signed(horizon_r)));
  assign fin_load = (state_r == S_FIN) && (!out_valid_r || !out_stall);

  // sequencer and next-state logic
  always_comb begin
    state_nxt     = state_r;
    pass_nxt      = pass_r;
    depth_nxt     = depth_r;
    roadw_nxt     = roadw_r;
    scr_w_nxt     = scr_w_r;
    scr_h_nxt     = scr_h_r;
    off_nxt       = off_r;
    slope_nxt     = slope_r;
    horizon_nxt   = horizon_r;
    last_x_nxt    = last_x_r;
    last_y_nxt    = last_y_r;
    last_w_nxt    = last_w_r;
    out_valid_nxt = out_valid_r;
    in_nxt        = in_r;
    out_data_nxt  = out_data_r;
    dz_nxt        = dz_r;
    dzpos_nxt     = dzpos_r;
    camlat_nxt    = camlat_r;
    qx_nxt        = qx_r;
    qy_nxt        = qy_r;
    stripe_nxt    = stripe_r;
    t_nxt         = t_r;
    n_nxt         = n_r;
    neg_nxt       = neg_r;
    fx_nxt        = fx_r;
    fy_nxt        = fy_r;
    fw_nxt        = fw_r;
    y_under_nxt   = y_under_r;
    mul_a         = '0;
    mul_b         = '0;
    div_start     = 1'b0;

    // result taken downstream
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // configuration writes
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CAMERA_DEPTH:  depth_nxt = cfg_wdata[DEPTH_W-1:0];
        CFG_ROAD_WIDTH:    roadw_nxt = cfg_wdata[ROADW_W-1:0];
        CFG_SCREEN_WIDTH:  scr_w_nxt = cfg_wdata[SCR_W-1:0];
        CFG_SCREEN_HEIGHT: scr_h_nxt = cfg_wdata[SCR_W-1:0];
      endcase
    end

    unique case (state_r)
      // wait for a segment; a new frame clears the curve and resets the horizon to the screen height
      S_IDLE: begin
        if (in_valid) begin
          in_nxt    = in_data;
          state_nxt = S_PREP;
          if (in_data.first_of_frame) begin
            off_nxt     = '0;
            slope_nxt   = '0;
            horizon_nxt = {4'b0000, scr_h_r};
          end
        end
      end
      // depth, camera position and elevation difference
      S_PREP: begin
        dz_nxt     = dz_w[DIV_DEN_W-1:0];
        dzpos_nxt  = !dz_w[24] && (dz_w[23:0] != '0);
        camlat_nxt = lat_w[32:8] + {24'b0, (lat_w[32] && (lat_w[7:0] != 8'h00))};
        qy_nxt     = {{2{in_r.seg_y[15]}}, in_r.seg_y} - {2'b00, in_r.cam_height};
        stripe_nxt = stripe_of(in_r.seg_index);
        pass_nxt   = PASS_X;
        state_nxt  = S_QX;
      end
      // lateral difference; segments behind the camera skip the math
      S_QX: begin
        qx_nxt = {{2{in_r.seg_x[23]}}, in_r.seg_x} - {camlat_r[24], camlat_r};
        if (dzpos_r) begin
          state_nxt = S_M1;
        end else begin
          fx_nxt      = '0;
          fy_nxt      = '0;
          fw_nxt      = '0;
          y_under_nxt = 1'b0;
          state_nxt   = S_FIN;
        end
      end
      // first product of the pass
      S_M1: begin
        unique case (pass_r)
          PASS_X: begin
            mul_a = {{3{qx_r[25]}}, qx_r};
            mul_b = {1'b0, depth_r};
          end
          PASS_Y: begin
            mul_a = {{11{qy_r[17]}}, qy_r};
            mul_b = {1'b0, depth_r};
          end
          PASS_W: begin
            mul_a = {13'b0, roadw_r};
            mul_b = {4'b0000, scr_w_r};
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
        state_nxt = S_T;
      end
      // term before the screen scale
      S_T: begin
        unique case (pass_r)
          PASS_X:  t_nxt = dz14 + prod[T_W-1:0];
          PASS_Y:  t_nxt = dz14 - prod[T_W-1:0];
          PASS_W:  t_nxt = prod[T_W-1:0];
          default: t_nxt = '0;
        endcase
        state_nxt = S_M2L;
      end
      // scale times low half of the term
      S_M2L: begin
        mul_a     = {{(MUL_A_W-SPLIT_W){1'b0}}, t_r[SPLIT_W-1:0]};
        mul_b     = scale_b;
        state_nxt = S_M2H;
      end
      // scale times high half of the term
      S_M2H: begin
        n_nxt     = {{(N_W-MUL_P_W){prod[MUL_P_W-1]}}, prod};
        mul_a     = {{(MUL_A_W-(T_W-SPLIT_W)){t_r[T_W-1]}}, t_r[T_W-1:SPLIT_W]};
        mul_b     = scale_b;
        state_nxt = S_N;
      end
      // combine the halves into the numerator
      S_N: begin
        n_nxt     = n_r + {prod[N_W-SPLIT_W-1:0], {SPLIT_W{1'b0}}};
        state_nxt = S_DS;
      end
      // launch the division by depth
      S_DS: begin
        div_start = 1'b1;
        neg_nxt   = n_r[N_W-1];
        state_nxt = S_DIV;
      end
      // collect the saturated quotient
      S_DIV: begin
        if (div_stat.done) begin
          unique case (pass_r)
            PASS_X: begin
              fx_nxt    = sval;
              pass_nxt  = PASS_Y;
              state_nxt = S_M1;
            end
            PASS_Y: begin
              fy_nxt      = sval;
              y_under_nxt = neg_r && sat_s;
              pass_nxt    = PASS_W;
              state_nxt   = S_M1;
            end
            PASS_W: begin
              fw_nxt    = wval;
              state_nxt = S_FIN;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      // load the result and advance the curve and horizon
      S_FIN: begin
        if (fin_load) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.visible       = vis_c;
          out_data_nxt.stripe        = stripe_r;
          out_data_nxt.near_x        = last_x_r;
          out_data_nxt.near_y        = last_y_r;
          out_data_nxt.near_half_w   = last_w_r;
          out_data_nxt.near_rumble_w = rumble_of(last_w_r);
          out_data_nxt.far_x         = fx_r;
          out_data_nxt.far_y         = fy_r;
          out_data_nxt.far_half_w    = fw_r;
          out_data_nxt.far_rumble_w  = rumble_of(fw_r);
          if (vis_c) begin
            horizon_nxt = fy_r;
          end
          last_x_nxt = fx_r;
          last_y_nxt = fy_r;
          last_w_nxt = fw_r;
          off_nxt    = off_r + slope_r;
          slope_nxt  = slope_r + {{16{in_r.seg_curve[15]}}, in_r.seg_curve};
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pass_r      <= PASS_X;
      depth_r     <= DEPTH_RST;
      roadw_r     <= ROADW_RST;
      scr_w_r     <= SCR_W_RST;
      scr_h_r     <= SCR_H_RST;
      off_r       <= '0;
      slope_r     <= '0;
      horizon_r   <= {4'b0000, SCR_H_RST};
      last_x_r    <= '0;
      last_y_r    <= '0;
      last_w_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pass_r      <= pass_nxt;
      depth_r     <= depth_nxt;
      roadw_r     <= roadw_nxt;
      scr_w_r     <= scr_w_nxt;
      scr_h_r     <= scr_h_nxt;
      off_r       <= off_nxt;
      slope_r     <= slope_nxt;
      horizon_r   <= horizon_nxt;
      last_x_r    <= last_x_nxt;
      last_y_r    <= last_y_nxt;
      last_w_r    <= last_w_nxt;
      out_valid_r <= out_valid_nxt;
    end
    in_r       <= in_nxt;
    out_data_r <= out_data_nxt;
    dz_r       <= dz_nxt;
    dzpos_r    <= dzpos_nxt;
    camlat_r   <= camlat_nxt;
    qx_r       <= qx_nxt;
    qy_r       <= qy_nxt;
    stripe_r   <= stripe_nxt;
    t_r        <= t_nxt;
    n_r        <= n_nxt;
    neg_r      <= neg_nxt;
    fx_r       <= fx_nxt;
    fy_r       <= fy_nxt;
    fw_r       <= fw_nxt;
    y_under_r  <= y_under_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `P3DRSP_ASSERT_NXT(a_accept_starts, in_valid && !in_stall, state_r == S_PREP)
  `P3DRSP_ASSERT_IMP(a_div_done_waiting, div_stat.done, state_r == S_DIV)
  `P3DRSP_ASSERT_NXT(a_horizon_follows, fin_load && vis_c,
                     horizon_r == out_data_r.far_y && out_data_r.visible)
  `P3DRSP_ASSERT_IMP(a_rumble_wider, out_valid_r,
                     out_data_r.far_rumble_w >= out_data_r.far_half_w &&
                     out_data_r.near_rumble_w >= out_data_r.near_half_w)

endmodule

`default_nettype wire
